[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the bond segment geometry checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define BSG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define BSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define BSG_ASSERT_RESET(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bsg_pkg.sv]
// ---------------------------------------------------------------------------
// bsg_pkg
// Widths, types and opcodes shared by the bond segment geometry block.
// ---------------------------------------------------------------------------
`default_nettype none

package bsg_pkg;

    localparam int COORD_W    = 24;
    localparam int SLOT_W     = 8;
    localparam int LEN_W      = COORD_W + 1;
    localparam int SUM_W      = 2 * LEN_W;
    localparam int REM_W      = LEN_W + 1;
    localparam int DIR_W      = 16;
    localparam int DIR_FRAC   = 14;
    localparam int QUOT_W     = DIR_FRAC + 1;
    localparam int RANGE_W    = 17;

    localparam int SQ_STEPS   = LEN_W;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_BOND  = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [LEN_W-1:0]          t_len;
    typedef logic signed [DIR_W-1:0]   t_dir;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_atom;

endpackage

`default_nettype wire

[src/bsg_in_if.sv]
// ---------------------------------------------------------------------------
// bsg_in_if
// Command channel: atom store and bond request words.
// ---------------------------------------------------------------------------
`default_nettype none

interface bsg_in_if import bsg_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SLOT_W-1:0]   atom_slot;
    t_coord              coord_x;
    t_coord              coord_y;
    t_coord              coord_z;
    logic [SLOT_W-1:0]   first_atom;
    logic [SLOT_W-1:0]   second_atom;

    modport source (
        output valid, opcode, atom_slot, coord_x, coord_y, coord_z,
               first_atom, second_atom,
        input  ready
    );

    modport sink (
        input  valid, opcode, atom_slot, coord_x, coord_y, coord_z,
               first_atom, second_atom,
        output ready
    );

endinterface

`default_nettype wire

[src/bsg_out_if.sv]
// ---------------------------------------------------------------------------
// bsg_out_if
// Result channel: bond midpoint height, length and unit direction.
// ---------------------------------------------------------------------------
`default_nettype none

interface bsg_out_if import bsg_pkg::*; ();

    logic   valid;
    logic   ready;
    t_coord mid_z;
    t_len   seg_length;
    t_dir   dir_x;
    t_dir   dir_y;
    logic   zero_length;

    modport source (
        output valid, mid_z, seg_length, dir_x, dir_y, zero_length,
        input  ready
    );

    modport sink (
        input  valid, mid_z, seg_length, dir_x, dir_y, zero_length,
        output ready
    );

endinterface

`default_nettype wire

[src/bsg_atom_store.sv]
// ---------------------------------------------------------------------------
// bsg_atom_store
// Atom coordinate table: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bsg_atom_store import bsg_pkg::*; #(
    parameter  int ATOM_DEPTH = 256,
    localparam int ADDR_W     = $clog2(ATOM_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_atom             i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_atom             o_rdata
);

    t_atom r_mem [ATOM_DEPTH];
    t_atom r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/bsg_sqsum.sv]
// ---------------------------------------------------------------------------
// bsg_sqsum
// Serial sum of squares: one multiplier bit of each magnitude per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bsg_sqsum import bsg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_len             i_mag_x,
    input  t_len             i_mag_y,
    output logic             o_done,
    output logic [SUM_W-1:0] o_sum
);

    logic                r_busy;
    logic                r_done;
    logic [SQ_CNT_W-1:0] r_cnt;
    t_len                r_mx;
    t_len                r_my;
    logic [SUM_W-1:0]    r_ax;
    logic [SUM_W-1:0]    r_ay;
    logic [SUM_W-1:0]    r_acc;
    logic [SUM_W-1:0]    n_acc;

    // add the shifted multiplicand wherever the multiplier bit is set
    always_comb begin
        n_acc = r_acc + (r_mx[0] ? r_ax : '0) + (r_my[0] ? r_ay : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_CNT_W'(SQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mx  <= i_mag_x;
            r_my  <= i_mag_y;
            r_ax  <= SUM_W'(i_mag_x);
            r_ay  <= SUM_W'(i_mag_y);
            r_acc <= '0;
        end else if (r_busy) begin
            r_mx  <= r_mx >> 1;
            r_my  <= r_my >> 1;
            r_ax  <= r_ax << 1;
            r_ay  <= r_ay << 1;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

`default_nettype wire

[src/bsg_isqrt.sv]
// ---------------------------------------------------------------------------
// bsg_isqrt
// Restoring integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bsg_isqrt import bsg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_value,
    output logic             o_done,
    output t_len             o_root
);

    logic                  r_busy;
    logic                  r_done;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]      r_val;
    logic [REM_W-1:0]      r_rem;
    t_len                  r_root;

    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      diff;
    logic                  fits;
    logic [REM_W-1:0]      n_rem;
    t_len                  n_root;

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
        rem_sh = {r_rem, r_val[SUM_W-1 -: 2]};
        trial  = (REM_W + 2)'({r_root, 2'b01});
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
        n_rem  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        n_root = {r_root[LEN_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= r_val << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[src/bsg_divider.sv]
// ---------------------------------------------------------------------------
// bsg_divider
// Restoring divider for magnitude * 2^14 / length, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bsg_divider import bsg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_len              i_num,
    input  t_len              i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [REM_W-1:0]     r_rem;
    t_len                 r_den;
    logic [QUOT_W-1:0]    r_quot;

    logic [REM_W-1:0]     den_ext;
    logic [REM_W-1:0]     diff;
    logic [REM_W-1:0]     kept;
    logic                 fits;
    logic [REM_W-1:0]     n_rem;
    logic [QUOT_W-1:0]    n_quot;

    // numerator never exceeds the length, so the top quotient bit is the
    // first compare and the rest follow from shifting in zeros
    always_comb begin
        den_ext = {1'b0, r_den};
        fits    = (r_rem >= den_ext);
        diff    = r_rem - den_ext;
        kept    = fits ? diff : r_rem;
        n_rem   = {kept[LEN_W-1:0], 1'b0};
        n_quot  = {r_quot[QUOT_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[src/bond_segment_geometry.sv]
// ---------------------------------------------------------------------------
// bond_segment_geometry
// Atom table with planar bond length and unit direction.
// i_in carries command words. A store word (opcode store) writes x, y, z
// of one atom and gives no result; slots at or above ATOM_DEPTH are
// dropped. A bond word names two atoms and gives one word on o_out:
// floored mean z, floored planar length and the Q1.14 direction.
// A bond runs serially: two table reads, a square sum, a square root
// (one root bit a cycle) and two parallel dividers. When both atoms
// share x and y the dividers are skipped and zero_length is set. No new
// word is taken until a bond has finished; store words are taken every
// cycle while idle. The result sits in an output register, so the next
// word is taken while it waits; a bond that finishes while the receiver
// still stalls holds until that register frees. Reset clears control
// state only; the table content is undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module bond_segment_geometry import bsg_pkg::*; #(
    parameter int ATOM_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsg_in_if.sink    i_in,
    bsg_out_if.source o_out
);

    localparam int ADDR_W = $clog2(ATOM_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ_A = 8'b0000_0010,
        S_READ_B = 8'b0000_0100,
        S_LOAD   = 8'b0000_1000,
        S_SQUARE = 8'b0001_0000,
        S_ROOT   = 8'b0010_0000,
        S_DIVIDE = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;

    logic [ADDR_W-1:0]   r_idx_a;
    logic [ADDR_W-1:0]   r_idx_b;
    logic                r_ok_a;
    logic                r_ok_b;
    t_atom               r_atom_a;
    t_coord              r_mid_z;
    t_len                r_mag_x;
    t_len                r_mag_y;
    logic                r_neg_x;
    logic                r_neg_y;
    logic                r_zero;

    logic                r_out_valid;
    t_coord              r_o_mid_z;
    t_len                r_o_len;
    t_dir                r_o_dir_x;
    t_dir                r_o_dir_y;
    logic                r_o_zero;

    logic                in_acc;
    logic [RANGE_W-1:0]  slot_ext;
    logic [RANGE_W-1:0]  first_ext;
    logic [RANGE_W-1:0]  second_ext;
    logic                store_we;
    t_atom               store_wdata;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    t_atom               rd_data;

    t_atom               atom_b;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] zsum;
    t_len                mag_x;
    t_len                mag_y;

    logic                sq_start;
    logic                sq_done;
    logic [SUM_W-1:0]    sq_sum;
    logic                root_start;
    logic                root_done;
    t_len                root;
    logic                div_start;
    logic                div_done_x;
    logic                div_done_y;
    logic [QUOT_W-1:0]   quot_x;
    logic [QUOT_W-1:0]   quot_y;
    logic                out_load;
    t_dir                dir_x;
    t_dir                dir_y;

    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_ext   = RANGE_W'(i_in.atom_slot);
    assign first_ext  = RANGE_W'(i_in.first_atom);
    assign second_ext = RANGE_W'(i_in.second_atom);

    assign store_we    = in_acc && (i_in.opcode == OP_STORE)
                         && (slot_ext < RANGE_W'(ATOM_DEPTH));
    assign store_wdata = {i_in.coord_x, i_in.coord_y, i_in.coord_z};
    assign rd_en       = (r_state == S_READ_A) || (r_state == S_READ_B);
    assign rd_addr     = (r_state == S_READ_A) ? r_idx_a : r_idx_b;

    bsg_atom_store #(
        .ATOM_DEPTH (ATOM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (slot_ext[ADDR_W-1:0]),
        .i_wdata (store_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // atom b arrives in the load cycle; out-of-range atoms read as origin
    always_comb begin
        atom_b = r_ok_b ? rd_data : '0;
        dx     = (COORD_W + 1)'(atom_b.x) - (COORD_W + 1)'(r_atom_a.x);
        dy     = (COORD_W + 1)'(atom_b.y) - (COORD_W + 1)'(r_atom_a.y);
        zsum   = (COORD_W + 1)'(atom_b.z) + (COORD_W + 1)'(r_atom_a.z);
        mag_x  = dx[COORD_W] ? t_len'(-dx) : t_len'(dx);
        mag_y  = dy[COORD_W] ? t_len'(-dy) : t_len'(dy);
    end

    assign sq_start   = (r_state == S_LOAD);
    assign root_start = (r_state == S_SQUARE) && sq_done;
    assign div_start  = (r_state == S_ROOT) && root_done && (root != '0);

    bsg_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_mag_x (mag_x),
        .i_mag_y (mag_y),
        .o_done  (sq_done),
        .o_sum   (sq_sum)
    );

    bsg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (sq_sum),
        .o_done  (root_done),
        .o_root  (root)
    );

    bsg_divider u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_mag_x),
        .i_den   (root),
        .o_done  (div_done_x),
        .o_quot  (quot_x)
    );

    bsg_divider u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_mag_y),
        .i_den   (root),
        .o_done  (div_done_y),
        .o_quot  (quot_y)
    );

    assign out_load = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);

    // restore the sign; a zero-length segment forces zero direction
    always_comb begin
        dir_x = '0;
        dir_y = '0;
        if (!r_zero) begin
            dir_x = r_neg_x ? -DIR_W'(quot_x) : DIR_W'(quot_x);
            dir_y = r_neg_y ? -DIR_W'(quot_y) : DIR_W'(quot_y);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.opcode == OP_BOND)) begin
                    n_state = S_READ_A;
                end
            end
            S_READ_A: begin
                n_state = S_READ_B;
            end
            S_READ_B: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_SQUARE;
            end
            S_SQUARE: begin
                if (sq_done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (root_done) begin
                    n_state = (root == '0) ? S_FINISH : S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (div_done_x && div_done_y) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.opcode == OP_BOND)) begin
            r_idx_a <= first_ext[ADDR_W-1:0];
            r_idx_b <= second_ext[ADDR_W-1:0];
            r_ok_a  <= (first_ext < RANGE_W'(ATOM_DEPTH));
            r_ok_b  <= (second_ext < RANGE_W'(ATOM_DEPTH));
        end
        if (r_state == S_READ_B) begin
            r_atom_a <= r_ok_a ? rd_data : '0;
        end
        if (r_state == S_LOAD) begin
            r_mid_z <= zsum[COORD_W:1];
            r_mag_x <= mag_x;
            r_mag_y <= mag_y;
            r_neg_x <= dx[COORD_W];
            r_neg_y <= dy[COORD_W];
        end
        if ((r_state == S_ROOT) && root_done) begin
            r_zero <= (root == '0);
        end
        if (out_load) begin
            r_o_mid_z <= r_mid_z;
            r_o_len   <= root;
            r_o_dir_x <= dir_x;
            r_o_dir_y <= dir_y;
            r_o_zero  <= r_zero;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.mid_z       = r_o_mid_z;
    assign o_out.seg_length  = r_o_len;
    assign o_out.dir_x       = r_o_dir_x;
    assign o_out.dir_y       = r_o_dir_y;
    assign o_out.zero_length = r_o_zero;

endmodule

`default_nettype wire

[src/bsg_checker.sv]
// ---------------------------------------------------------------------------
// bsg_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bsg_checker import bsg_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_coord i_mid_z,
    input t_len   i_seg_length,
    input t_dir   i_dir_x,
    input t_dir   i_dir_y,
    input logic   i_zero_length
);

    localparam t_dir DIR_ONE = DIR_W'(1 << DIR_FRAC);

    `BSG_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped while stalled")

    `BSG_ASSERT_NEXT(a_word_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_mid_z) && $stable(i_seg_length) && $stable(i_dir_x) && $stable(i_dir_y) && $stable(i_zero_length), "result word changed while stalled")

    `BSG_ASSERT_IMPL(a_zero_flag, i_clk, i_rst_n, i_out_valid, (i_zero_length == (i_seg_length == '0)) && (!i_zero_length || ((i_dir_x == '0) && (i_dir_y == '0))), "zero-length flag disagrees with length or direction")

    `BSG_ASSERT_IMPL(a_dir_range, i_clk, i_rst_n, i_out_valid, (i_dir_x <= DIR_ONE) && (i_dir_x >= -DIR_ONE) && (i_dir_y <= DIR_ONE) && (i_dir_y >= -DIR_ONE), "direction outside unit range")

    `BSG_ASSERT_RESET(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid, "result valid straight after reset")

endmodule

bind bond_segment_geometry bsg_checker u_bsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_mid_z       (o_out.mid_z),
    .i_seg_length  (o_out.seg_length),
    .i_dir_x       (o_out.dir_x),
    .i_dir_y       (o_out.dir_y),
    .i_zero_length (o_out.zero_length)
);

`default_nettype wire

[sim/tb_bond_segment_geometry.sv]
// ---------------------------------------------------------------------------
// tb_bond_segment_geometry
// Self-checking bench for the atom table and bond geometry block.
// Store and bond words go in through the command channel. A scoreboard keeps
// its own atom table and works out mean z, floored planar length and the
// Q1.14 direction for each bond taken. It then compares every result word,
// field by field, in order. The run holds a directed opening of corner cases
// and four phases of random traffic with different sender and receiver
// idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_bond_segment_geometry;

    timeunit 1ns;
    timeprecision 1ps;

    import bsg_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int RUN_LIMIT    = 500000;
    localparam int PHASE_WORDS  = 200;
    localparam int SETTLE_CYC   = 80;      // longer than the bond latency
    localparam t_coord COORD_MAX = t_coord'(24'h7FFFFF);
    localparam t_coord COORD_MIN = t_coord'(24'h800000);

    typedef struct {
        logic              opcode;
        logic [SLOT_W-1:0] atom_slot;
        t_coord            coord_x;
        t_coord            coord_y;
        t_coord            coord_z;
        logic [SLOT_W-1:0] first_atom;
        logic [SLOT_W-1:0] second_atom;
    } t_bond_cmd;

    typedef struct {
        t_coord mid_z;
        t_len   seg_length;
        t_dir   dir_x;
        t_dir   dir_y;
        logic   zero_length;
    } t_bond_result;

    class t_bond_scoreboard;
        t_atom        atoms [TABLE_DEPTH];
        bit           written [TABLE_DEPTH];
        t_bond_result pending [$];
        int           mismatches;
        int           stores_seen;
        int           bonds_checked;
        int           zero_segments;

        function new();
            mismatches    = 0;
            stores_seen   = 0;
            bonds_checked = 0;
            zero_segments = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        task report(string msg);
            if (mismatches < 30) $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function automatic longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned root = 0;
            longint unsigned bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    -= root + bitv;
                    root  = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // Signed d * 2^14 / len, truncated toward zero
        function automatic t_dir unit_share(longint d, longint unsigned len);
            longint unsigned m = (d < 0) ? longint'(-d) : longint'(d);
            longint unsigned q = (m << DIR_FRAC) / len;
            if (d < 0) q = -q;
            return t_dir'(q);
        endfunction

        function automatic t_bond_result bond_geometry(t_atom a, t_atom b);
            t_bond_result    r;
            logic signed [LEN_W-1:0] zsum;
            longint          dx;
            longint          dy;
            longint unsigned mx;
            longint unsigned my;
            longint unsigned len;
            zsum    = a.z + b.z;
            r.mid_z = t_coord'(zsum >>> 1);
            dx      = longint'(b.x) - longint'(a.x);
            dy      = longint'(b.y) - longint'(a.y);
            mx      = (dx < 0) ? longint'(-dx) : longint'(dx);
            my      = (dy < 0) ? longint'(-dy) : longint'(dy);
            len     = floor_sqrt(mx * mx + my * my);
            r.seg_length = t_len'(len);
            if (len == 0) begin
                r.dir_x       = '0;
                r.dir_y       = '0;
                r.zero_length = 1'b1;
            end else begin
                r.dir_x       = unit_share(dx, len);
                r.dir_y       = unit_share(dy, len);
                r.zero_length = 1'b0;
            end
            return r;
        endfunction

        function void note_word(t_bond_cmd w);
            if (w.opcode == OP_STORE) begin
                atoms[w.atom_slot].x = w.coord_x;
                atoms[w.atom_slot].y = w.coord_y;
                atoms[w.atom_slot].z = w.coord_z;
                written[w.atom_slot] = 1'b1;
                stores_seen++;
            end else begin
                pending.push_back(bond_geometry(atoms[w.first_atom],
                                                atoms[w.second_atom]));
            end
        endfunction

        task check_result(t_bond_result got);
            t_bond_result exp;
            if (pending.size() == 0) begin
                report("result word with no bond outstanding");
                return;
            end
            exp = pending.pop_front();
            bonds_checked++;
            if (exp.zero_length) zero_segments++;
            if (got.mid_z !== exp.mid_z)
                report($sformatf("mid_z got %0d exp %0d", got.mid_z, exp.mid_z));
            if (got.seg_length !== exp.seg_length)
                report($sformatf("seg_length got %0d exp %0d",
                                 got.seg_length, exp.seg_length));
            if (got.dir_x !== exp.dir_x)
                report($sformatf("dir_x got %0d exp %0d", got.dir_x, exp.dir_x));
            if (got.dir_y !== exp.dir_y)
                report($sformatf("dir_y got %0d exp %0d", got.dir_y, exp.dir_y));
            if (got.zero_length !== exp.zero_length)
                report($sformatf("zero_length got %b exp %b",
                                 got.zero_length, exp.zero_length));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsg_in_if  in_bus ();
    bsg_out_if out_bus ();

    bond_segment_geometry #(.ATOM_DEPTH(TABLE_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_bond_scoreboard sb = new();
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               stored_slots [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: take result words and throttle ready
    always @(posedge i_clk) begin
        t_bond_result r;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            r.mid_z       = out_bus.mid_z;
            r.seg_length  = out_bus.seg_length;
            r.dir_x       = out_bus.dir_x;
            r.dir_y       = out_bus.dir_y;
            r.zero_length = out_bus.zero_length;
            sb.check_result(r);
        end
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", RUN_LIMIT);
        $display("tb_bond_segment_geometry: FAIL");
        $finish;
    end

    task send_word(t_bond_cmd w);
        while ($urandom_range(99) < idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.opcode      <= w.opcode;
        in_bus.atom_slot   <= w.atom_slot;
        in_bus.coord_x     <= w.coord_x;
        in_bus.coord_y     <= w.coord_y;
        in_bus.coord_z     <= w.coord_z;
        in_bus.first_atom  <= w.first_atom;
        in_bus.second_atom <= w.second_atom;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        sb.note_word(w);
        if (w.opcode == OP_STORE && !(w.atom_slot inside {stored_slots}))
            stored_slots.push_back(w.atom_slot);
    endtask

    // Ignored fields carry random junk
    task store_atom(int slot, t_coord x, t_coord y, t_coord z);
        t_bond_cmd w;
        w.opcode      = OP_STORE;
        w.atom_slot   = slot[SLOT_W-1:0];
        w.coord_x     = x;
        w.coord_y     = y;
        w.coord_z     = z;
        w.first_atom  = SLOT_W'($urandom);
        w.second_atom = SLOT_W'($urandom);
        send_word(w);
    endtask

    task bond_atoms(int first, int second);
        t_bond_cmd w;
        w.opcode      = OP_BOND;
        w.atom_slot   = SLOT_W'($urandom);
        w.coord_x     = t_coord'($urandom);
        w.coord_y     = t_coord'($urandom);
        w.coord_z     = t_coord'($urandom);
        w.first_atom  = first[SLOT_W-1:0];
        w.second_atom = second[SLOT_W-1:0];
        send_word(w);
    endtask

    // Hold the sender until every bond has come back
    task drain_bonds();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    function automatic t_coord pick_coord();
        int mode;
        int near;
        mode = $urandom_range(9);
        near = $urandom_range(8192);
        case (mode) inside
            [0:3]:   return t_coord'($urandom);
            [4:6]:   return t_coord'(near - 4096);
            7:       return COORD_MAX;
            8:       return COORD_MIN;
            default: return t_coord'($urandom_range(1) ? -1 : 0);
        endcase
    endfunction

    task random_word();
        int     pick;
        int     first;
        int     second;
        t_coord x;
        t_coord y;
        pick = $urandom_range(99);
        if (stored_slots.size() == 0 || pick < 40) begin
            x = pick_coord();
            y = pick_coord();
            // Copy x and y of a stored atom now and then, for zero-length bonds
            if (stored_slots.size() != 0 && $urandom_range(99) < 20) begin
                first = stored_slots[$urandom_range(stored_slots.size() - 1)];
                x = sb.atoms[first].x;
                y = sb.atoms[first].y;
            end
            store_atom($urandom_range(TABLE_DEPTH - 1), x, y, pick_coord());
        end else begin
            first  = stored_slots[$urandom_range(stored_slots.size() - 1)];
            second = ($urandom_range(99) < 10) ? first :
                     stored_slots[$urandom_range(stored_slots.size() - 1)];
            bond_atoms(first, second);
        end
    endtask

    initial begin : stimulus
        in_bus.valid       <= 1'b0;
        in_bus.opcode      <= OP_STORE;
        in_bus.atom_slot   <= '0;
        in_bus.coord_x     <= '0;
        in_bus.coord_y     <= '0;
        in_bus.coord_z     <= '0;
        in_bus.first_atom  <= '0;
        in_bus.second_atom <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: corners of the coordinate range and special segments
        store_atom(0,   COORD_MAX, COORD_MAX, COORD_MAX);
        store_atom(255, COORD_MIN, COORD_MIN, COORD_MIN);
        bond_atoms(0, 255);                    // longest diagonal, negative
        bond_atoms(255, 0);                    // longest diagonal, positive
        bond_atoms(0, 0);                      // zero length at top of range
        bond_atoms(255, 255);                  // zero length at bottom of range
        store_atom(1, COORD_MAX, COORD_MIN, -24'sd1);
        store_atom(2, COORD_MIN, COORD_MIN, 24'sd0);
        store_atom(3, COORD_MAX, COORD_MAX, 24'sd1);
        bond_atoms(1, 2);                      // pure -x, full unit
        bond_atoms(1, 3);                      // pure +y, full unit
        store_atom(4, 24'sd0, 24'sd0, -24'sd3);
        store_atom(5, 24'sd1, 24'sd1, 24'sd0);
        store_atom(6, 24'sd0, 24'sd0, 24'sd7);
        store_atom(7, 24'sd3, 24'sd4, -24'sd8);
        bond_atoms(4, 5);                      // unit step, odd negative z sum
        bond_atoms(4, 6);                      // same x and y, z differs
        bond_atoms(4, 7);                      // 3-4-5 triangle
        bond_atoms(7, 4);
        store_atom(4, 24'sd5, -24'sd12, 24'sd2); // overwrite a slot
        bond_atoms(4, 0);
        bond_atoms(5, 4);
        bond_atoms(2, 255);
        drain_bonds();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 45; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            repeat (PHASE_WORDS) random_word();
            drain_bonds();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d bond results never arrived", sb.pending.size()));

        $display("covered %0d store words and %0d bond results (%0d zero-length)",
                 sb.stores_seen, sb.bonds_checked, sb.zero_segments);
        $display("across four idling phases; %0d mismatches", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_bond_segment_geometry: PASS");
        end else begin
            $display("tb_bond_segment_geometry: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
